// ===== design/sfs_pkg.sv =====
// Shared types and constants of the sprite frame sequencer.
package sfs_pkg;

   localparam int PosWidth = 27;
   localparam int FracWidth = 16;
   localparam int CountWidth = 9;
   localparam int SpeedWidth = 16;
   localparam int DeltaWidth = 24;
   localparam int HoldWidth = 24;
   localparam int LoopWidth = 16;
   localparam int CsrIndexWidth = 2;
   localparam int CsrDataWidth = 16;

   typedef enum logic [1:0] {
      KIND_TICK = 2'd0,
      KIND_RESTART = 2'd1,
      KIND_SPEED = 2'd2
   } kind_type;

   typedef enum logic [CsrIndexWidth-1:0] {
      CSR_FRAME_COUNT = 2'd0,
      CSR_BASE_SPEED = 2'd1,
      CSR_LOOP_ENABLE = 2'd2,
      CSR_PLAY_FORWARD = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [CountWidth-1:0] eff_count;
      logic loop_enable;
      logic play_forward;
   } play_cfg_type;

   typedef struct packed {
      logic do_tick;
      logic do_restart;
   } adv_ctrl_type;

   typedef struct packed {
      logic signed [PosWidth-1:0] pos;
      logic [CountWidth-1:0] frame;
      logic wrapped;
      logic finished;
   } adv_result_type;

endpackage

// ===== design/sfs_advance.sv =====
// Position update, frame selection and end detection for one item.
module sfs_advance (
   input sfs_pkg::play_cfg_type cfg,
   input sfs_pkg::adv_ctrl_type ctrl,
   input logic signed [sfs_pkg::PosWidth-1:0] pos,
   input logic [sfs_pkg::DeltaWidth-1:0] delta,
   output sfs_pkg::adv_result_type result
);

   localparam int PW = sfs_pkg::PosWidth;
   localparam int FW = sfs_pkg::FracWidth;
   localparam int CW = sfs_pkg::CountWidth;
   localparam logic signed [PW-1:0] PosMax = {1'b0, {(PW-1){1'b1}}};
   localparam logic signed [PW-1:0] PosMin = {1'b1, {(PW-1){1'b0}}};

   logic signed [PW:0] pos_ext;
   logic signed [PW:0] delta_ext;
   logic signed [PW:0] sum_up;
   logic signed [PW:0] sum_down;
   logic signed [PW-1:0] pos_up;
   logic signed [PW-1:0] pos_down;
   logic signed [PW-1:0] end_pos;
   logic signed [PW-1:0] last_pos;
   logic [CW-1:0] last_frame;
   logic signed [PW-1:0] tick_pos;
   logic tick_wrap;
   logic signed [PW-1:0] pos_next;
   logic [PW-FW-2:0] int_part;

   assign last_frame = cfg.eff_count - CW'(1);
   assign end_pos = $signed({{(PW-CW-FW){1'b0}}, cfg.eff_count, {FW{1'b0}}});
   assign last_pos = $signed({{(PW-CW-FW){1'b0}}, last_frame, {FW{1'b0}}});

   assign pos_ext = {pos[PW-1], pos};
   assign delta_ext = $signed({{(PW+1-sfs_pkg::DeltaWidth){1'b0}}, delta});
   assign sum_up = pos_ext + delta_ext;
   assign sum_down = pos_ext - delta_ext;

   always_comb begin
      if (sum_up[PW] != sum_up[PW-1]) begin
         pos_up = sum_up[PW] ? PosMin : PosMax;
      end else begin
         pos_up = sum_up[PW-1:0];
      end
      if (sum_down[PW] != sum_down[PW-1]) begin
         pos_down = sum_down[PW] ? PosMin : PosMax;
      end else begin
         pos_down = sum_down[PW-1:0];
      end
   end

   always_comb begin
      tick_pos = pos;
      tick_wrap = 1'b0;
      if (cfg.loop_enable) begin
         if (cfg.play_forward) begin
            if (pos_up >= end_pos) begin
               tick_pos = '0;
               tick_wrap = 1'b1;
            end else begin
               tick_pos = pos_up;
            end
         end else begin
            if (pos_down < 0) begin
               tick_pos = last_pos;
               tick_wrap = 1'b1;
            end else begin
               tick_pos = pos_down;
            end
         end
      end else begin
         if (cfg.play_forward) begin
            if (pos <= end_pos) tick_pos = pos_up;
         end else begin
            if (pos >= 0) tick_pos = pos_down;
         end
      end
   end

   always_comb begin
      if (ctrl.do_tick) begin
         pos_next = tick_pos;
      end else if (ctrl.do_restart) begin
         pos_next = cfg.play_forward ? '0 : last_pos;
      end else begin
         pos_next = pos;
      end
   end

   assign int_part = pos_next[PW-2:FW];

   always_comb begin
      result.pos = pos_next;
      result.wrapped = ctrl.do_tick & tick_wrap;
      if (pos_next < 0) begin
         result.frame = '0;
      end else if ({1'b0, int_part} > {{(PW-FW-CW){1'b0}}, last_frame}) begin
         result.frame = last_frame;
      end else begin
         result.frame = int_part[CW-1:0];
      end
      if (cfg.play_forward) begin
         result.finished = ~cfg.loop_enable & (pos_next >= end_pos);
      end else begin
         result.finished = ~cfg.loop_enable & (pos_next < 0);
      end
   end

endmodule

// ===== design/sprite_frame_sequencer_top.sv =====
// Sprite frame sequencer: fractional frame position, loop and speed control.
//
// Each item is captured in an input register when it is accepted, then one
// pass of logic (one speed-by-time multiply, a saturating position add and
// the end compare) updates the playback state and loads the result register.
// A new item is accepted every cycle as long as the result side keeps taking
// results, so throughput is one item per cycle.
// Configuration writes are taken at any time and act at once; a write of
// base_speed also drops any temporary speed change.
module sprite_frame_sequencer_top #(
   parameter int MAX_FRAMES = 256
) (
   input logic clock,
   input logic reset,
   input logic req_valid,
   output logic req_ready,
   input logic [1:0] req_kind,
   input logic [15:0] req_elapsed,
   input logic [11:0] req_ratio,
   input logic [23:0] req_hold_time,
   output logic rsp_valid,
   input logic rsp_ready,
   output logic [7:0] rsp_frame_index,
   output logic rsp_finished,
   output logic rsp_restarted,
   output logic [15:0] rsp_loops_done,
   output logic rsp_speed_held,
   input logic csr_valid,
   output logic csr_ready,
   input logic [sfs_pkg::CsrIndexWidth-1:0] csr_index,
   input logic [sfs_pkg::CsrDataWidth-1:0] csr_data
);

   localparam int CW = sfs_pkg::CountWidth;
   localparam int SW = sfs_pkg::SpeedWidth;
   localparam int HW = sfs_pkg::HoldWidth;
   localparam int LW = sfs_pkg::LoopWidth;
   localparam logic [CW-1:0] FrameCap =
      (MAX_FRAMES > (2 ** CW - 1)) ? {CW{1'b1}} : CW'(MAX_FRAMES);

   // configuration
   logic [CW-1:0] eff_count_ff, eff_count_in;
   logic [SW-1:0] base_speed_ff;
   logic loop_enable_ff;
   logic play_forward_ff;
   logic [CW-1:0] csr_count;
   logic csr_write;
   logic base_write;

   // input stage
   logic in_valid_ff;
   logic [1:0] kind_ff;
   logic [15:0] elapsed_ff;
   logic [11:0] ratio_ff;
   logic [HW-1:0] hold_time_ff;

   // playback state
   logic signed [sfs_pkg::PosWidth-1:0] position_ff;
   logic [CW-1:0] shown_frame_ff, shown_frame_in;
   logic [SW-1:0] current_speed_ff, current_speed_in;
   logic altered_ff, altered_in;
   logic [HW-1:0] hold_elapsed_ff, hold_elapsed_in;
   logic [HW-1:0] hold_limit_ff, hold_limit_in;
   logic [LW-1:0] loop_count_ff, loop_count_in;

   // result stage
   logic rsp_valid_ff;
   logic [7:0] frame_index_ff;
   logic finished_ff;
   logic restarted_ff, restarted_in;
   logic [LW-1:0] loops_done_ff;
   logic speed_held_ff;

   logic advance;
   logic do_tick, do_restart, do_speed;
   logic [HW:0] hold_sum;
   logic [HW-1:0] hold_sat;
   logic hold_expired;
   logic [SW-1:0] tick_speed;
   logic [31:0] tick_product;
   logic [27:0] speed_product;
   logic [19:0] scaled_speed;
   sfs_pkg::play_cfg_type play_cfg;
   sfs_pkg::adv_ctrl_type adv_ctrl;
   sfs_pkg::adv_result_type adv_result;

   assign advance = in_valid_ff & (~rsp_valid_ff | rsp_ready);
   assign req_ready = ~in_valid_ff | advance;
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid & csr_ready;
   assign base_write = csr_write & (csr_index == sfs_pkg::CSR_BASE_SPEED);

   assign csr_count = csr_data[CW-1:0];
   always_comb begin
      if (csr_count == '0) begin
         eff_count_in = CW'(1);
      end else if (csr_count > FrameCap) begin
         eff_count_in = FrameCap;
      end else begin
         eff_count_in = csr_count;
      end
   end

   always_comb begin
      do_tick = 1'b0;
      do_restart = 1'b0;
      do_speed = 1'b0;
      unique case (kind_ff)
         sfs_pkg::KIND_TICK: do_tick = 1'b1;
         sfs_pkg::KIND_RESTART: do_restart = 1'b1;
         sfs_pkg::KIND_SPEED: do_speed = 1'b1;
         default: ;
      endcase
   end

   // hold timer runs only while a speed change is in effect
   assign hold_sum = {1'b0, hold_elapsed_ff} + {{(HW - 15){1'b0}}, elapsed_ff};
   assign hold_sat = hold_sum[HW] ? {HW{1'b1}} : hold_sum[HW-1:0];
   assign hold_expired = altered_ff & (hold_sat >= hold_limit_ff);
   assign tick_speed = hold_expired ? base_speed_ff : current_speed_ff;
   assign tick_product = 32'(tick_speed) * 32'(elapsed_ff);

   assign speed_product = 28'(current_speed_ff) * 28'(ratio_ff);
   assign scaled_speed = speed_product[27:8];

   assign play_cfg = '{eff_count: eff_count_ff, loop_enable: loop_enable_ff,
                       play_forward: play_forward_ff};
   assign adv_ctrl = '{do_tick: do_tick, do_restart: do_restart};

   sfs_advance u_advance (
      .cfg(play_cfg),
      .ctrl(adv_ctrl),
      .pos(position_ff),
      .delta(tick_product[31:8]),
      .result(adv_result)
   );

   always_comb begin
      shown_frame_in = shown_frame_ff;
      current_speed_in = current_speed_ff;
      altered_in = altered_ff;
      hold_elapsed_in = hold_elapsed_ff;
      hold_limit_in = hold_limit_ff;
      loop_count_in = loop_count_ff;
      restarted_in = 1'b0;
      if (do_tick) begin
         shown_frame_in = adv_result.frame;
         if (hold_expired) begin
            current_speed_in = base_speed_ff;
            altered_in = 1'b0;
            hold_elapsed_in = '0;
         end else if (altered_ff) begin
            hold_elapsed_in = hold_sat;
         end
         if (adv_result.wrapped) begin
            restarted_in = 1'b1;
            if (loop_count_ff != {LW{1'b1}}) loop_count_in = loop_count_ff + LW'(1);
         end
      end else if (do_restart) begin
         shown_frame_in = adv_result.frame;
         current_speed_in = base_speed_ff;
         altered_in = 1'b0;
         hold_elapsed_in = '0;
         loop_count_in = '0;
         restarted_in = 1'b1;
      end else if (do_speed) begin
         current_speed_in = (scaled_speed[19:16] != '0) ? {SW{1'b1}} : scaled_speed[15:0];
         hold_limit_in = hold_time_ff;
         hold_elapsed_in = '0;
         altered_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         eff_count_ff <= CW'(1);
         base_speed_ff <= SW'(256);
         loop_enable_ff <= 1'b1;
         play_forward_ff <= 1'b1;
         in_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
         position_ff <= '0;
         shown_frame_ff <= '0;
         current_speed_ff <= SW'(256);
         altered_ff <= 1'b0;
         hold_elapsed_ff <= '0;
         hold_limit_ff <= '0;
         loop_count_ff <= '0;
      end else begin
         if (req_valid & req_ready) begin
            in_valid_ff <= 1'b1;
         end else if (advance) begin
            in_valid_ff <= 1'b0;
         end
         if (advance) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         if (advance) begin
            position_ff <= adv_result.pos;
            shown_frame_ff <= shown_frame_in;
            hold_limit_ff <= hold_limit_in;
            loop_count_ff <= loop_count_in;
         end
         // a base speed write drops any temporary speed change
         if (base_write) begin
            current_speed_ff <= csr_data[SW-1:0];
            altered_ff <= 1'b0;
            hold_elapsed_ff <= '0;
         end else if (advance) begin
            current_speed_ff <= current_speed_in;
            altered_ff <= altered_in;
            hold_elapsed_ff <= hold_elapsed_in;
         end
         if (csr_write) begin
            unique case (csr_index)
               sfs_pkg::CSR_FRAME_COUNT: eff_count_ff <= eff_count_in;
               sfs_pkg::CSR_BASE_SPEED: base_speed_ff <= csr_data[SW-1:0];
               sfs_pkg::CSR_LOOP_ENABLE: loop_enable_ff <= csr_data[0];
               sfs_pkg::CSR_PLAY_FORWARD: play_forward_ff <= csr_data[0];
               default: ;
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_valid & req_ready) begin
         kind_ff <= req_kind;
         elapsed_ff <= req_elapsed;
         ratio_ff <= req_ratio;
         hold_time_ff <= req_hold_time;
      end
      if (advance) begin
         frame_index_ff <= shown_frame_in[7:0];
         finished_ff <= adv_result.finished;
         restarted_ff <= restarted_in;
         loops_done_ff <= loop_count_in;
         speed_held_ff <= altered_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_frame_index = frame_index_ff;
   assign rsp_finished = finished_ff;
   assign rsp_restarted = restarted_ff;
   assign rsp_loops_done = loops_done_ff;
   assign rsp_speed_held = speed_held_ff;

endmodule
